// File: hw/rtl/ted_pkg.sv
// Shared types, byte patterns and result codes of the text encoding detector.
package ted_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned EncW  = 3;

  typedef logic [ByteW-1:0] byte_t;
  typedef logic [EncW-1:0]  enc_t;

  // Result codes
  localparam enc_t ENC_UTF8_BOM = 3'd0;
  localparam enc_t ENC_UTF16_LE = 3'd1;
  localparam enc_t ENC_UTF16_BE = 3'd2;
  localparam enc_t ENC_UTF8     = 3'd3;
  localparam enc_t ENC_GBK      = 3'd4;

  // Byte order marks
  localparam byte_t BOM8_B0  = 8'hEF;
  localparam byte_t BOM8_B1  = 8'hBB;
  localparam byte_t BOM8_B2  = 8'hBF;
  localparam byte_t BYTE_FF  = 8'hFF;
  localparam byte_t BYTE_FE  = 8'hFE;

  // UTF-8 structure patterns
  localparam byte_t ASCII_MAX  = 8'h7F;
  localparam byte_t MASK_2B    = 8'hE0;
  localparam byte_t LEAD_2B    = 8'hC0;
  localparam byte_t MASK_3B    = 8'hF0;
  localparam byte_t LEAD_3B    = 8'hE0;
  localparam byte_t MASK_4B    = 8'hF8;
  localparam byte_t LEAD_4B    = 8'hF0;
  localparam byte_t MASK_CONT  = 8'hC0;
  localparam byte_t CONT_TAG   = 8'h80;

  typedef struct packed {
    byte_t data_byte;
    logic  has_byte;
    logic  last_byte;
  } item_t;

  typedef struct packed {
    logic valid;
    enc_t code;
  } result_t;

endpackage

// File: hw/rtl/ted_if.sv
// Valid/ready channel interfaces for byte input and encoding result.
interface ted_in_if import ted_pkg::*; ();
  logic  valid;
  logic  ready;
  byte_t data_byte;
  logic  has_byte;
  logic  last_byte;

  modport source (output valid, output data_byte, output has_byte, output last_byte,
                  input ready);
  modport sink   (input valid, input data_byte, input has_byte, input last_byte,
                  output ready);
endinterface

interface ted_out_if import ted_pkg::*; ();
  logic valid;
  logic ready;
  enc_t encoding_code;

  modport source (output valid, output encoding_code, input ready);
  modport sink   (input valid, input encoding_code, output ready);
endinterface

// File: hw/rtl/ted_in_stage.sv
// Input register stage: captures one word per cycle from the input channel while the register is empty or advancing.
module ted_in_stage import ted_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  ted_in_if.sink    in_ch,
  input  logic      adv,
  output logic      s1_valid,
  output item_t     s1_item
);

  logic  valid_r, valid_nxt;
  item_t item_r;
  logic  take;

  assign in_ch.ready = !valid_r || adv;
  assign take        = in_ch.valid && in_ch.ready;
  assign valid_nxt   = take ? 1'b1 : (adv ? 1'b0 : valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      item_r <= '{data_byte: in_ch.data_byte, has_byte: in_ch.has_byte,
                  last_byte: in_ch.last_byte};
    end
  end

  assign s1_valid = valid_r;
  assign s1_item  = item_r;

endmodule

// File: hw/rtl/ted_scan.sv
// Per-stream scan state: BOM match flags, UTF-8 structure check, classifier.
module ted_scan import ted_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    step,
  input  item_t   item,
  output result_t res
);

  logic [1:0] pos_r, pos_nxt, pos_t;
  logic       bom_r, bom_nxt, bom_t;
  logic       le_r, le_nxt, le_t;
  logic       be_r, be_nxt, be_t;
  logic [1:0] pend_r, pend_nxt, pend_t;
  logic       sv_r, sv_nxt, sv_t;
  byte_t      b;
  enc_t       code;

  assign b = item.data_byte;

  // State after taking this word's byte
  always_comb begin
    pos_t  = pos_r;
    bom_t  = bom_r;
    le_t   = le_r;
    be_t   = be_r;
    pend_t = pend_r;
    sv_t   = sv_r;
    if (item.has_byte) begin
      case (pos_r)
        2'd0: begin
          bom_t = bom_r && (b == BOM8_B0);
          le_t  = le_r  && (b == BYTE_FF);
          be_t  = be_r  && (b == BYTE_FE);
        end
        2'd1: begin
          bom_t = bom_r && (b == BOM8_B1);
          le_t  = le_r  && (b == BYTE_FE);
          be_t  = be_r  && (b == BYTE_FF);
        end
        2'd2: begin
          bom_t = bom_r && (b == BOM8_B2);
        end
        default: ;
      endcase
      if (pos_r != 2'd3) begin
        pos_t = pos_r + 2'd1;
      end
      if (pend_r != 2'd0) begin
        if ((b & MASK_CONT) != CONT_TAG) begin
          sv_t = 1'b0;
        end
        pend_t = pend_r - 2'd1;
      end else if (b <= ASCII_MAX) begin
        pend_t = 2'd0;
      end else if ((b & MASK_2B) == LEAD_2B) begin
        pend_t = 2'd1;
      end else if ((b & MASK_3B) == LEAD_3B) begin
        pend_t = 2'd2;
      end else if ((b & MASK_4B) == LEAD_4B) begin
        pend_t = 2'd3;
      end else begin
        sv_t = 1'b0;
      end
    end
  end

  // Classification, BOMs first in priority order
  always_comb begin
    if (pos_t == 2'd3 && bom_t) begin
      code = ENC_UTF8_BOM;
    end else if (pos_t >= 2'd2 && le_t) begin
      code = ENC_UTF16_LE;
    end else if (pos_t >= 2'd2 && be_t) begin
      code = ENC_UTF16_BE;
    end else if (sv_t && pend_t == 2'd0) begin
      code = ENC_UTF8;
    end else begin
      code = ENC_GBK;
    end
  end

  always_comb begin
    pos_nxt  = pos_r;
    bom_nxt  = bom_r;
    le_nxt   = le_r;
    be_nxt   = be_r;
    pend_nxt = pend_r;
    sv_nxt   = sv_r;
    if (step) begin
      if (item.last_byte) begin
        pos_nxt  = 2'd0;
        bom_nxt  = 1'b1;
        le_nxt   = 1'b1;
        be_nxt   = 1'b1;
        pend_nxt = 2'd0;
        sv_nxt   = 1'b1;
      end else begin
        pos_nxt  = pos_t;
        bom_nxt  = bom_t;
        le_nxt   = le_t;
        be_nxt   = be_t;
        pend_nxt = pend_t;
        sv_nxt   = sv_t;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= 2'd0;
      bom_r  <= 1'b1;
      le_r   <= 1'b1;
      be_r   <= 1'b1;
      pend_r <= 2'd0;
      sv_r   <= 1'b1;
    end else begin
      pos_r  <= pos_nxt;
      bom_r  <= bom_nxt;
      le_r   <= le_nxt;
      be_r   <= be_nxt;
      pend_r <= pend_nxt;
      sv_r   <= sv_nxt;
    end
  end

  assign res.valid = step && item.last_byte;
  assign res.code  = code;

  // End of stream leaves a fresh scan state
  a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    step && item.last_byte |=> pos_r == 2'd0 && pend_r == 2'd0 && sv_r && bom_r)
    else $error("scan state not cleared after last word");

  // No byte seen yet means nothing can have been ruled out
  a_fresh_consistent: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r == 2'd0 |-> bom_r && le_r && be_r && sv_r && pend_r == 2'd0)
    else $error("scan flags changed with no byte taken");

endmodule

// File: hw/rtl/ted_out_stage.sv
// Result register: holds one encoding code until the receiver takes it.
module ted_out_stage import ted_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  result_t  res,
  output logic     room,
  ted_out_if.source out_ch
);

  logic valid_r, valid_nxt;
  enc_t code_r;

  assign room = !valid_r || out_ch.ready;

  always_comb begin
    valid_nxt = valid_r;
    if (res.valid) begin
      valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res.valid) begin
      code_r <= res.code;
    end
  end

  assign out_ch.valid         = valid_r;
  assign out_ch.encoding_code = code_r;

endmodule

// File: hw/rtl/text_encoding_detector_core.sv
// Top level of the text encoding detector: input stage, scanner, result register.
//
// Usage: bytes of one text stream arrive as words on in_ch, one byte per word
// (data_byte valid when has_byte is 1), with last_byte set on the stream's
// final word. A word with has_byte = 0 and last_byte = 1 ends a stream (or
// marks an empty one); has_byte = 0 and last_byte = 0 is an idle word.
// Each stream yields exactly one word on out_ch: encoding_code 0 UTF-8 BOM,
// 1 UTF-16 LE, 2 UTF-16 BE, 3 UTF-8, 4 GBK. Scan state clears after it.
// Path: a last word accepted on in_ch first sits in the input register; the
// scan logic then loads the result register when that register has room.
// Throughput: one word per cycle while no last word waits for room; the per-byte update is a handful of gates
// between the input register and the scan/result registers.
// Stall: while the result register holds an untaken result, non-last words
// keep flowing; a last word waits in the input register, and in_ch.ready
// drops only when that register is also occupied.
// Reset (synchronous, rst_n low): channels empty, scan state fresh.
module text_encoding_detector_core import ted_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  ted_in_if.sink     in_ch,
  ted_out_if.source  out_ch
);

  logic    s1_valid;
  item_t   s1_item;
  logic    room;
  logic    adv;
  result_t res;

  // Non-last words never need the result register
  assign adv = s1_valid && (!s1_item.last_byte || room);

  ted_in_stage u_in (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .adv      (adv),
    .s1_valid (s1_valid),
    .s1_item  (s1_item)
  );

  ted_scan u_scan (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (adv),
    .item  (s1_item),
    .res   (res)
  );

  ted_out_stage u_out (
    .clk    (clk),
    .rst_n  (rst_n),
    .res    (res),
    .room   (room),
    .out_ch (out_ch)
  );

  // A finished stream always lands in the result register
  a_last_lands: assert property (@(posedge clk) disable iff (!rst_n)
    adv && s1_item.last_byte |=> out_ch.valid)
    else $error("stream end produced no result");

  // An empty input register never backpressures
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !s1_valid |-> in_ch.ready)
    else $error("input stalled with empty stage");

endmodule

// File: sim/text_encoding_detector_core_test.sv
// Self-checking testbench for text_encoding_detector_core: random and directed byte streams.
`timescale 1ns / 100ps

module text_encoding_detector_core_test import ted_pkg::*; ();

  localparam int unsigned ItemTarget = 1650;   // stream words (idle words not counted)
  localparam int unsigned CycleLimit = 200000; // far above the slowest legal run
  localparam int unsigned ReportMax  = 10;     // mismatches printed in full
  localparam int unsigned DrainWait  = 8;      // settle time after the last expected result is taken

  // Scan-state predictor plus the queue of encoding codes still owed by the block.
  class encoding_scoreboard;
    int unsigned prefix_len;   // bytes seen, saturates at 3
    bit          bom8_ok;      // leading bytes still agree with EF BB BF
    bit          le_ok;        // ... with FF FE
    bit          be_ok;        // ... with FE FF
    bit [1:0]    cont_owed;    // continuation bytes still expected
    bit          utf8_ok;      // no structure fault so far
    enc_t        code_q[$];
    int unsigned mismatches;

    function new();
      mismatches = 0;
      clear_scan();
    endfunction

    function void clear_scan();
      prefix_len = 0;
      bom8_ok    = 1'b1;
      le_ok      = 1'b1;
      be_ok      = 1'b1;
      cont_owed  = 2'd0;
      utf8_ok    = 1'b1;
    endfunction

    function enc_t classify();
      if (prefix_len >= 3 && bom8_ok) return ENC_UTF8_BOM;
      if (prefix_len >= 2 && le_ok)   return ENC_UTF16_LE;
      if (prefix_len >= 2 && be_ok)   return ENC_UTF16_BE;
      if (utf8_ok && cont_owed == 2'd0) return ENC_UTF8;
      return ENC_GBK;
    endfunction

    // One accepted input word.
    function void note_word(byte_t b, logic has, logic last);
      if (has) begin
        case (prefix_len)
          0: begin
            bom8_ok = bom8_ok && (b == BOM8_B0);
            le_ok   = le_ok   && (b == BYTE_FF);
            be_ok   = be_ok   && (b == BYTE_FE);
          end
          1: begin
            bom8_ok = bom8_ok && (b == BOM8_B1);
            le_ok   = le_ok   && (b == BYTE_FE);
            be_ok   = be_ok   && (b == BYTE_FF);
          end
          2: bom8_ok = bom8_ok && (b == BOM8_B2);
          default: ;
        endcase
        if (prefix_len < 3) prefix_len++;

        // an owed continuation eats the byte even when it is malformed
        if (cont_owed != 2'd0) begin
          if ((b & MASK_CONT) != CONT_TAG) utf8_ok = 1'b0;
          cont_owed = cont_owed - 2'd1;
        end else if (b <= ASCII_MAX) begin
        end else if ((b & MASK_2B) == LEAD_2B) begin
          cont_owed = 2'd1;
        end else if ((b & MASK_3B) == LEAD_3B) begin
          cont_owed = 2'd2;
        end else if ((b & MASK_4B) == LEAD_4B) begin
          cont_owed = 2'd3;
        end else begin
          utf8_ok = 1'b0;  // stray continuation or 11111xxx
        end
      end
      if (last) begin
        code_q.push_back(classify());
        clear_scan();
      end
    endfunction

    // One accepted result word.
    function void check_result(enc_t got);
      enc_t want;
      if (code_q.size() == 0) begin
        mismatches++;
        if (mismatches <= ReportMax)
          $display("%0t: unexpected result word, encoding_code %0d", $time, got);
        return;
      end
      want = code_q.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= ReportMax)
          $display("%0t: encoding_code mismatch: expected %0d, got %0d", $time, want, got);
      end
    endfunction

    function int unsigned pending();
      return code_q.size();
    endfunction
  endclass

  logic clk;
  logic rst_n;

  ted_in_if  in_ch ();
  ted_out_if out_ch ();

  text_encoding_detector_core dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  encoding_scoreboard sb;

  byte_t       stream_q[$];  // bytes of the stream being built
  int unsigned items_sent;   // words carrying a byte or an end mark
  int unsigned cycle_count;
  bit          src_idles;    // sender may insert gaps
  bit          sink_stalls;  // receiver may drop ready

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Receiver: ready low with a chance of about 30 in 100 while stalls are on.
  always @(posedge clk) begin
    out_ch.ready <= sink_stalls ? ($urandom_range(0, 99) >= 30) : 1'b1;
  end

  // Monitors sample at the edge, before any register in the block updates.
  always @(posedge clk) begin
    if (rst_n && in_ch.valid && in_ch.ready)
      sb.note_word(in_ch.data_byte, in_ch.has_byte, in_ch.last_byte);
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready)
      sb.check_result(out_ch.encoding_code);
  end

  // Watchdog.
  initial begin
    cycle_count = 0;
    while (cycle_count < CycleLimit) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("text_encoding_detector_core_test: FAIL");
    $finish;
  end

  // Drive one word and hold it until the block takes it. Valid is driven low for
  // a gap, if one is inserted, and then high for the word.
  task automatic send_word(input byte_t b, input logic has, input logic last);
    if (src_idles && $urandom_range(0, 99) < 30) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.data_byte <= b;
    in_ch.has_byte  <= has;
    in_ch.last_byte <= last;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    if (has || last) items_sent++;
  endtask

  // Send stream_q as one stream. With end_mark the stream closes on a
  // byte-less last word; an empty queue always does. Idle words are sprinkled in.
  task automatic play_stream(input bit end_mark);
    int n;
    n = stream_q.size();
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 19) == 0) send_word(byte_t'($urandom), 1'b0, 1'b0);
      send_word(stream_q[i], 1'b1, !end_mark && i == n - 1);
    end
    if (end_mark || n == 0) send_word(byte_t'($urandom), 1'b0, 1'b1);
  endtask

  function automatic byte_t cont_byte();
    byte_t v;
    v = byte_t'($urandom);
    v[7:6] = 2'b10;
    return v;
  endfunction

  // Append well-formed characters of random length and content.
  function automatic void add_chars(int unsigned count);
    byte_t       v;
    int unsigned len;
    repeat (count) begin
      len = $urandom_range(1, 4);
      v = byte_t'($urandom);
      case (len)
        1: v[7]   = 1'b0;
        2: v[7:5] = 3'b110;
        3: v[7:4] = 4'b1110;
        default: v[7:3] = 5'b11110;
      endcase
      stream_q.push_back(v);
      repeat (len - 1) stream_q.push_back(cont_byte());
    end
  endfunction

  // Mostly well-formed text, with BOM-led streams, broken text and raw noise.
  function automatic void make_random_stream();
    int unsigned kind;
    int unsigned pos;
    byte_t       v;
    stream_q.delete();
    kind = $urandom_range(0, 99);
    if (kind < 15) begin
      case ($urandom_range(0, 2))
        0: stream_q = '{BOM8_B0, BOM8_B1, BOM8_B2};
        1: stream_q = '{BYTE_FF, BYTE_FE};
        default: stream_q = '{BYTE_FE, BYTE_FF};
      endcase
      if ($urandom_range(0, 3) == 0) void'(stream_q.pop_back());  // mark cut short
      add_chars($urandom_range(0, 4));
    end else if (kind < 65) begin
      add_chars($urandom_range(0, 6));
    end else if (kind < 85) begin
      add_chars($urandom_range(1, 6));
      pos = $urandom_range(0, stream_q.size() - 1);
      case ($urandom_range(0, 3))
        0: stream_q[pos] = byte_t'($urandom);
        1: void'(stream_q.pop_back());          // truncated sequence
        2: stream_q.insert(pos, cont_byte());   // stray continuation
        default: begin                          // 11111xxx byte
          v = byte_t'($urandom);
          v[7:3] = 5'b11111;
          stream_q.insert(pos, v);
        end
      endcase
    end else begin
      repeat ($urandom_range(1, 8)) stream_q.push_back(byte_t'($urandom));
    end
  endfunction

  initial begin
    bit quiet;
    sb = new();
    items_sent  = 0;
    src_idles   = 1'b1;
    sink_stalls = 1'b1;

    rst_n           = 1'b0;
    in_ch.valid     = 1'b0;
    in_ch.data_byte = '0;
    in_ch.has_byte  = 1'b0;
    in_ch.last_byte = 1'b0;
    out_ch.ready    = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Directed streams.
    stream_q.delete();
    play_stream(1'b0);                                    // empty stream
    stream_q = '{BOM8_B0, BOM8_B1, BOM8_B2};
    play_stream(1'b0);                                    // exact UTF-8 BOM
    stream_q = '{BYTE_FF, BYTE_FE};
    play_stream(1'b0);                                    // UTF-16 LE mark
    stream_q = '{BYTE_FE, BYTE_FF};
    play_stream(1'b0);                                    // UTF-16 BE mark
    send_word(8'h41, 1'b1, 1'b0);                         // a byte, then an idle word mid-stream,
    send_word(8'hA5, 1'b0, 1'b0);                         // then a byte and an end word without byte
    send_word(8'h7F, 1'b1, 1'b0);
    send_word(8'hFF, 1'b0, 1'b1);
    stream_q = '{8'hC3, 8'h00};
    play_stream(1'b0);                                    // bad continuation
    stream_q = '{8'h80};
    play_stream(1'b0);                                    // stray continuation
    stream_q = '{8'hF8};
    play_stream(1'b0);                                    // 11111xxx lead
    stream_q = '{8'hF0, 8'h9F, 8'h98, 8'h80};
    play_stream(1'b0);                                    // four-byte character
    stream_q = '{8'hE2, 8'h82};
    play_stream(1'b0);                                    // cut off at the end
    stream_q = '{BOM8_B0, BOM8_B1};
    play_stream(1'b0);                                    // BOM too short to count

    // Random streams; a quiet window without gaps or stalls in the middle.
    while (items_sent < ItemTarget) begin
      quiet = items_sent >= 700 && items_sent < 950;
      src_idles   = !quiet;
      sink_stalls = !quiet;
      make_random_stream();
      play_stream($urandom_range(0, 9) == 0);
    end
    in_ch.valid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (DrainWait) @(posedge clk);

    if (sb.mismatches == 0 && sb.pending() == 0)
      $display("text_encoding_detector_core_test: PASS");
    else
      $display("text_encoding_detector_core_test: FAIL");
    $finish;
  end

endmodule

// File: filelist.f
hw/rtl/ted_pkg.sv
hw/rtl/ted_if.sv
hw/rtl/ted_in_stage.sv
hw/rtl/ted_scan.sv
hw/rtl/ted_out_stage.sv
hw/rtl/text_encoding_detector_core.sv
sim/text_encoding_detector_core_test.sv
